// ===== src/sibs_pkg.sv =====
// ----------------------------------------------------------------------------
// sibs_pkg
// Shared types and constants for the sorted index binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sibs_pkg;

  localparam int unsigned SIBS_DEPTH_DEFAULT = 1024;
  localparam int unsigned KEY_W              = 32;
  localparam int unsigned POS_W              = 32;
  localparam int unsigned ENTRY_COUNT_W      = 11;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_SHIFT_END,
    S_PUT,
    S_FINISH
  } state_t;

  typedef struct packed {
    func_t                    func;
    logic signed [KEY_W-1:0]  key;
    logic        [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    status_t                    status;
    logic [POS_W-1:0]           found_position;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } out_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic        [POS_W-1:0]  position;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/sibs_mem.sv =====
// ----------------------------------------------------------------------------
// sibs_mem
// Table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sibs_mem
  import sibs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = SIBS_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sibs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sibs_ctrl
// Sequencer: binary search probes, insertion shift and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module sibs_ctrl
  import sibs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = SIBS_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire in_word_t      in_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output out_word_t          res_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire entry_t        rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output entry_t             wr_data
);

  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           lo_r, lo_nxt, hi_r, hi_nxt, count_r, count_nxt;
  logic [AW-1:0]           mid_r, mid_nxt, src_r, src_nxt, wr_dst_r, wr_dst_nxt;
  logic                    wr_pend_r, wr_pend_nxt;
  func_t                   func_r, func_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt, res_pos_r, res_pos_nxt;
  status_t                 res_st_r, res_st_nxt;

  logic [CW-1:0]           nlo, nhi, cnt_mid, srch_mid;
  logic                    go_right, is_lookup;
  logic [CW+ENTRY_COUNT_W-1:0] cnt_ext;

  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo,
                                           input logic [CW-1:0] hi,
                                           input logic          lk);
    logic [CW-1:0] d;
    d = hi - lo - CW'(lk);
    return lo + (d >> 1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    src_r     <= src_nxt;
    wr_dst_r  <= wr_dst_nxt;
    func_r    <= func_nxt;
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    res_pos_r <= res_pos_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign is_lookup = (func_r == FUNC_LOOKUP);
  assign go_right  = is_lookup ? (rd_data.key < key_r) : (rd_data.key <= key_r);
  assign nlo       = go_right ? (CW'(mid_r) + CW'(1)) : lo_r;
  assign nhi       = go_right ? hi_r : CW'(mid_r);
  assign srch_mid  = mid_of(nlo, nhi, is_lookup);
  assign cnt_mid   = mid_of('0, count_r, (in_data.func == FUNC_LOOKUP));
  assign cnt_ext   = {{ENTRY_COUNT_W{1'b0}}, count_r};

  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    src_nxt     = src_r;
    wr_dst_nxt  = wr_dst_r;
    wr_pend_nxt = 1'b0;
    count_nxt   = count_r;
    func_nxt    = func_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    res_pos_nxt = res_pos_r;
    res_st_nxt  = res_st_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = mid_r;
    wr_en       = wr_pend_r;
    wr_addr     = wr_dst_r;
    wr_data     = rd_data;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt    = in_data.func;
          key_nxt     = in_data.key;
          pos_nxt     = in_data.position;
          lo_nxt      = '0;
          hi_nxt      = count_r;
          res_pos_nxt = '0;
          res_st_nxt  = ST_OK;
          if (in_data.func == FUNC_INSERT && count_r == FULL_CNT) begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_FINISH;
          end else if (count_r != '0) begin
            mid_nxt   = cnt_mid[AW-1:0];
            rd_en     = 1'b1;
            rd_addr   = cnt_mid[AW-1:0];
            state_nxt = S_SEARCH;
          end else if (in_data.func == FUNC_LOOKUP) begin
            res_st_nxt = ST_NOT_FOUND;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end
      S_SEARCH: begin
        if (is_lookup && rd_data.key == key_r) begin
          res_pos_nxt = rd_data.position;
          state_nxt   = S_FINISH;
        end else begin
          lo_nxt = nlo;
          hi_nxt = nhi;
          if (nlo < nhi) begin
            mid_nxt = srch_mid[AW-1:0];
            rd_en   = 1'b1;
            rd_addr = srch_mid[AW-1:0];
          end else if (is_lookup) begin
            res_st_nxt = ST_NOT_FOUND;
            state_nxt  = S_FINISH;
          end else if (nlo < count_r) begin
            src_nxt   = AW'(count_r - CW'(1));
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end
      S_SHIFT: begin
        rd_en       = 1'b1;
        rd_addr     = src_r;
        wr_pend_nxt = 1'b1;
        wr_dst_nxt  = src_r + AW'(1);
        if (src_r == lo_r[AW-1:0]) begin
          state_nxt = S_SHIFT_END;
        end else begin
          src_nxt = src_r - AW'(1);
        end
      end
      S_SHIFT_END: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = lo_r[AW-1:0];
        wr_data   = '{key: key_r, position: pos_r};
        count_nxt = count_r + CW'(1);
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_data = '{status:         res_st_r,
                      found_position: res_pos_r,
                      entry_count:    cnt_ext[ENTRY_COUNT_W-1:0]};

endmodule

`default_nettype wire

// ===== src/sibs_out.sv =====
// ----------------------------------------------------------------------------
// sibs_out
// Result output register: holds one word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sibs_out
  import sibs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  output logic           res_ready,
  input  wire out_word_t res_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/sorted_index_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_index_binary_search
// Sorted (key, position) table with sorted insertion and binary search lookup.
// ----------------------------------------------------------------------------
// One word is in work at a time; a finished result waits in the output
// register while the next word is taken. A lookup makes one memory probe per
// cycle until it hits or its range is empty. An insert searches the same way
// and then moves each entry above the new slot up by one before writing the
// new entry; the single read port of the table memory serialises the probes
// and the shift. A refused insert on a full table makes no probe. The table
// starts empty after reset; no clearing pass is run.
`default_nettype none

module sorted_index_binary_search
  import sibs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = SIBS_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic          rd_en, wr_en, res_valid, res_ready;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  out_word_t     res_data;

  sibs_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sibs_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  sibs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/sibs_chk.sv =====
// ----------------------------------------------------------------------------
// sibs_chk
// Port-level checks for the sorted index binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

module sibs_chk
  import sibs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = SIBS_DEPTH_DEFAULT
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  localparam logic [ENTRY_COUNT_W-1:0] FULL_COUNT = ENTRY_COUNT_W'(TABLE_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.found_position == '0)
    else $error("position not zero on a refused or missed word");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == FULL_COUNT)
    else $error("table full reported below capacity");

endmodule

bind sorted_index_binary_search sibs_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (.*);

`default_nettype wire

// ===== bench/sorted_index_binary_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_index_binary_search_tb
// Drives insert and lookup words into the sorted index table and checks every
// result word against a local model of the table, with random gaps on both
// handshakes. Covers the empty table, extreme and equal keys, a long random
// mix and the table-full refusal.
// ----------------------------------------------------------------------------

module sorted_index_binary_search_tb;
  import sibs_pkg::*;

  localparam int unsigned DEPTH = SIBS_DEPTH_DEFAULT;
  localparam int RANDOM_WORDS = 1850;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic signed [KEY_W-1:0] tbl_key [DEPTH];
  logic        [POS_W-1:0] tbl_pos [DEPTH];
  int          tbl_count = 0;

  out_word_t   pending_results [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned ready_hold = 0;

  sorted_index_binary_search #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    int        slot;
    int        i;
    int        lo;
    int        hi;
    int        mid;
    bit        hit;
    r = '0;
    if (w.func == FUNC_INSERT) begin
      if (tbl_count >= int'(DEPTH)) begin
        r.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < tbl_count && tbl_key[slot] <= $signed(w.key)) slot++;
        for (i = tbl_count; i > slot; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_pos[i] = tbl_pos[i-1];
        end
        tbl_key[slot] = w.key;
        tbl_pos[slot] = w.position;
        tbl_count++;
        r.status = ST_OK;
      end
    end else begin
      lo  = 0;
      hi  = tbl_count - 1;
      hit = 1'b0;
      while (!hit && lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (tbl_key[mid] == $signed(w.key)) begin
          hit = 1'b1;
          r.found_position = tbl_pos[mid];
        end else if (tbl_key[mid] < $signed(w.key)) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      r.status = hit ? ST_OK : ST_NOT_FOUND;
    end
    r.entry_count = ENTRY_COUNT_W'(tbl_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = $urandom_range(80, 20);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && tbl_count != 0) return tbl_key[$urandom_range(tbl_count - 1)];
    if (r < 55) return int'($urandom_range(16)) - 8;
    if (r < 65) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh8000_0001;
        3: return 32'sh7fff_fffe;
        4: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  // call at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input func_t f, input logic signed [KEY_W-1:0] k,
                           input logic [POS_W-1:0] p);
    in_word_t    w;
    int unsigned gap;
    w.func     = f;
    w.key      = k;
    w.position = p;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results = {pending_results, apply_word(w)};
  endtask

  task automatic test_empty_lookup();
    send_word(FUNC_LOOKUP, 32'sd0, $urandom());
    send_word(FUNC_LOOKUP, 32'sh8000_0000, $urandom());
  endtask

  task automatic test_extreme_keys();
    send_word(FUNC_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
    send_word(FUNC_INSERT, 32'sh8000_0000, 32'h0000_0000);
    send_word(FUNC_INSERT, 32'sd0, 32'h1234_5678);
    send_word(FUNC_INSERT, -32'sd1, 32'h8000_0000);
    send_word(FUNC_INSERT, 32'sd1, 32'h7fff_ffff);
    send_word(FUNC_INSERT, 32'sh8000_0001, 32'h5555_aaaa);
    send_word(FUNC_LOOKUP, 32'sh7fff_ffff, 32'h0);
    send_word(FUNC_LOOKUP, 32'sh8000_0000, 32'hffff_ffff);
    send_word(FUNC_LOOKUP, 32'sd0, $urandom());
    send_word(FUNC_LOOKUP, -32'sd1, $urandom());
    send_word(FUNC_LOOKUP, 32'sh8000_0001, $urandom());
    send_word(FUNC_LOOKUP, 32'sd2, $urandom());
  endtask

  task automatic test_equal_keys();
    send_word(FUNC_INSERT, 32'sd7, 32'h0000_0070);
    send_word(FUNC_INSERT, 32'sd7, 32'h0000_0071);
    send_word(FUNC_INSERT, 32'sd7, 32'h0000_0072);
    send_word(FUNC_LOOKUP, 32'sd7, $urandom());
    send_word(FUNC_LOOKUP, 32'sd8, $urandom());
  endtask

  task automatic test_random_mix();
    int i;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(99) < 60) send_word(FUNC_INSERT, pick_key(), $urandom());
      else send_word(FUNC_LOOKUP, pick_key(), $urandom());
    end
  endtask

  task automatic test_full_table();
    int i;
    while (tbl_count < int'(DEPTH)) send_word(FUNC_INSERT, pick_key(), $urandom());
    for (i = 0; i < 4; i++) send_word(FUNC_INSERT, pick_key(), $urandom());
    send_word(FUNC_LOOKUP, tbl_key[0], $urandom());
    send_word(FUNC_LOOKUP, tbl_key[DEPTH-1], $urandom());
    send_word(FUNC_LOOKUP, pick_key(), $urandom());
  endtask

  always @(posedge clk) begin
    int unsigned r;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(99);
      if (r < 10) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(80, 20);
      end else if (r < 70) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(3, 0);
      end else if (r < 93) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(2, 0);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(40, 5);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          fail_count++;
        end
        if (out_data.found_position !== want.found_position) begin
          $display("%0t: found_position expected %h actual %h", $time,
                   want.found_position, out_data.found_position);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   want.entry_count, out_data.entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_lookup();
    test_extreme_keys();
    test_equal_keys();
    test_random_mix();
    test_full_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 32) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
